// ----- rtl/ita_pkg.sv -----
`timescale 1ns / 1ps

package ita_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;  // enough for 4294967295
  localparam int unsigned NumNibs   = DataW / DigitW;
  localparam int unsigned CharW     = 8;
  localparam int unsigned RemW      = $clog2(NumDigits + 1);
  localparam int unsigned BitCntW   = $clog2(DataW);

  localparam logic ModeDec = 1'b0;
  localparam logic ModeHex = 1'b1;

  localparam logic [CharW-1:0] CharZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] CharAlpha = 8'h61;  // 'a'
  localparam logic [CharW-1:0] CharMinus = 8'h2d;  // '-'

  typedef logic [DigitW-1:0] digit_t;

  typedef enum logic [1:0] {
    CellHold  = 2'd0,
    CellLoad  = 2'd1,
    CellDabble = 2'd2,
    CellShift = 2'd3
  } cell_op_e;

  function automatic logic [CharW-1:0] digit_to_ascii(input digit_t d);
    logic [CharW-1:0] c;
    if (d < digit_t'(10)) begin
      c = CharZero + CharW'(d);
    end else begin
      c = CharAlpha + CharW'(d) - CharW'(10);
    end
    return c;
  endfunction

endpackage

// ----- rtl/ita_cell.sv -----
`timescale 1ns / 1ps

// One digit of the converter row. Dabble: add 3 when >= 5, then shift in a bit
// from the lower neighbor; the carry goes up. Shift: take the lower neighbor's digit.
module ita_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ita_pkg::cell_op_e  op_i,
  input  ita_pkg::digit_t    load_i,
  input  logic               bit_i,
  input  ita_pkg::digit_t    digit_i,
  output logic               bit_o,
  output ita_pkg::digit_t    digit_o
);

  ita_pkg::digit_t digit_q, digit_d, adj;

  always_comb begin
    if (digit_q >= ita_pkg::digit_t'(5)) begin
      adj = digit_q + ita_pkg::digit_t'(3);
    end else begin
      adj = digit_q;
    end
  end

  always_comb begin
    unique case (op_i)
      ita_pkg::CellHold:   digit_d = digit_q;
      ita_pkg::CellLoad:   digit_d = load_i;
      ita_pkg::CellDabble: digit_d = {adj[ita_pkg::DigitW-2:0], bit_i};
      ita_pkg::CellShift:  digit_d = digit_i;
      default:             digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign bit_o   = adj[ita_pkg::DigitW-1];
  assign digit_o = digit_q;

endmodule

// ----- rtl/integer_to_ascii_formatter.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Fields
// in      | input     | in_valid_i/in_stall_o  | mode_i, value_i
// out     | output    | out_valid_o/out_stall_i| character_o, last_o
//
// One word at a time: accept, bit-serial double dabble of all 32 bits through
// the ten digit cells, a shift for each dropped leading zero, then one
// character per cycle (sign included) while the output is not stalled.
// Hex loads the cells directly and skips the conversion.
// Reset clears control and the output valid. A stalled output holds the
// character and pauses emission; a new word is taken once emission is done.
module integer_to_ascii_formatter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [ita_pkg::DataW-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ita_pkg::CharW-1:0]  character_o,
  output logic                       last_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StConv = 5'b00010,
    StSkip = 5'b00100,
    StSign = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [ita_pkg::DataW-1:0]   mag_q, mag_d;
  logic [ita_pkg::BitCntW-1:0] cnt_q, cnt_d;
  logic [ita_pkg::RemW-1:0]    rem_q, rem_d;
  logic                        neg_q, neg_d;
  logic                        out_valid_q, out_valid_d;
  logic [ita_pkg::CharW-1:0]   char_q, char_d;
  logic                        last_q, last_d;

  ita_pkg::cell_op_e op;
  ita_pkg::digit_t   load_nib [ita_pkg::NumDigits];
  ita_pkg::digit_t   digits   [ita_pkg::NumDigits];
  logic              carry    [ita_pkg::NumDigits-1];
  ita_pkg::digit_t   top;
  logic              accept, slot_free;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign top        = digits[ita_pkg::NumDigits-1];

  // hex mode fills the low cells with nibbles; decimal starts from zero
  always_comb begin
    for (int i = 0; i < int'(ita_pkg::NumDigits); i++) begin
      load_nib[i] = '0;
    end
    if (mode_i == ita_pkg::ModeHex) begin
      for (int i = 0; i < int'(ita_pkg::NumNibs); i++) begin
        load_nib[i] = value_i[i*ita_pkg::DigitW +: ita_pkg::DigitW];
      end
    end
  end

  for (genvar g = 0; g < ita_pkg::NumDigits; g++) begin : g_cell
    if (g == 0) begin : g_first
      ita_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .op_i    (op),
        .load_i  (load_nib[g]),
        .bit_i   (mag_q[ita_pkg::DataW-1]),
        .digit_i ('0),
        .bit_o   (carry[g]),
        .digit_o (digits[g])
      );
    end else if (g == ita_pkg::NumDigits - 1) begin : g_last
      // magnitude fits in ten digits, top carry is always zero
      ita_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .op_i    (op),
        .load_i  (load_nib[g]),
        .bit_i   (carry[g-1]),
        .digit_i (digits[g-1]),
        .bit_o   (),
        .digit_o (digits[g])
      );
    end else begin : g_mid
      ita_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .op_i    (op),
        .load_i  (load_nib[g]),
        .bit_i   (carry[g-1]),
        .digit_i (digits[g-1]),
        .bit_o   (carry[g]),
        .digit_o (digits[g])
      );
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    op          = ita_pkg::CellHold;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          op    = ita_pkg::CellLoad;
          cnt_d = '0;
          if (mode_i == ita_pkg::ModeHex) begin
            neg_d   = 1'b0;
            // nibbles sit in the low cells; the skip walks them up to the top
            rem_d   = ita_pkg::RemW'(ita_pkg::NumDigits);
            state_d = StSkip;
          end else begin
            neg_d   = value_i[ita_pkg::DataW-1];
            mag_d   = value_i[ita_pkg::DataW-1] ? (~value_i + 1'b1) : value_i;
            state_d = StConv;
          end
        end
      end
      StConv: begin
        op    = ita_pkg::CellDabble;
        mag_d = {mag_q[ita_pkg::DataW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          rem_d   = ita_pkg::RemW'(ita_pkg::NumDigits);
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (top == '0 && rem_q > ita_pkg::RemW'(1)) begin
          op    = ita_pkg::CellShift;
          rem_d = rem_q - 1'b1;
        end else begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = ita_pkg::CharMinus;
          last_d      = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          op          = ita_pkg::CellShift;
          out_valid_d = 1'b1;
          char_d      = ita_pkg::digit_to_ascii(top);
          last_d      = (rem_q == ita_pkg::RemW'(1));
          rem_d       = rem_q - 1'b1;
          if (rem_q == ita_pkg::RemW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// ----- dv/tb_integer_to_ascii_formatter.sv -----
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned WordsPerPhase = 140;

  typedef struct packed {
    logic [ita_pkg::CharW-1:0] code;
    logic                      last;
  } text_char_t;

  // Expected character stream, one entry per output character.
  class text_scoreboard;
    text_char_t  expected_chars[$];
    int unsigned errors;
    int unsigned dec_words;
    int unsigned hex_words;
    int unsigned chars_seen;

    function void note_word(logic mode, logic [ita_pkg::DataW-1:0] value);
      logic [ita_pkg::DataW-1:0] mag;
      logic [ita_pkg::CharW-1:0] digs[$];
      logic [3:0]                nib;
      text_char_t                c;
      mag = value;
      digs = {};
      if (mode == ita_pkg::ModeDec) begin
        dec_words++;
        if (value[ita_pkg::DataW-1]) begin
          mag = ~value + 1'b1;  // most negative stays 0x80000000 = 2147483648
          c.code = ita_pkg::CharMinus;
          c.last = 1'b0;
          expected_chars.push_back(c);
        end
        do begin
          digs.push_front(ita_pkg::CharZero + ita_pkg::CharW'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
      end else begin
        hex_words++;
        do begin
          nib = mag[3:0];
          digs.push_front(nib < 4'd10 ?
                          ita_pkg::CharZero + ita_pkg::CharW'(nib) :
                          ita_pkg::CharAlpha + ita_pkg::CharW'(nib) -
                          ita_pkg::CharW'(10));
          mag = mag >> 4;
        end while (mag != 0);
      end
      foreach (digs[i]) begin
        c.code = digs[i];
        c.last = (i == digs.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [ita_pkg::CharW-1:0] code, logic last);
      text_char_t exp_c;
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: code %h last %b", code, last);
        errors++;
        return;
      end
      exp_c = expected_chars.pop_front();
      if (code !== exp_c.code) begin
        $error("character mismatch: expected %h actual %h", exp_c.code, code);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last mismatch: expected %b actual %b", exp_c.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      mode_i = ita_pkg::ModeDec;
  logic [ita_pkg::DataW-1:0] value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [ita_pkg::CharW-1:0] character_o;
  logic                      last_o;

  text_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  integer_to_ascii_formatter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output side: check accepted characters, then pick next cycle's stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_char(character_o, last_o);
    end
    if (hold_reqs != holds_served) begin
      holds_served++;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_word(input logic mode, input logic [ita_pkg::DataW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(mode, value);
  endtask

  // Mix of full-range words and values near digit-count boundaries.
  function automatic logic [ita_pkg::DataW-1:0] pick_value();
    logic [ita_pkg::DataW-1:0] v;
    int unsigned               k;
    k = $urandom_range(ita_pkg::DataW - 1);
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(20);
      2: v = ita_pkg::DataW'(1) << k;
      3: v = (ita_pkg::DataW'(1) << k) - 1'b1;
      4: v = -ita_pkg::DataW'($urandom_range(1, 1000));
      default: begin
        v = 1;
        repeat ($urandom_range(9)) v = v * 10;
        v = v + $urandom_range(2) - 1;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic run_random(input int unsigned n);
    repeat (n) send_word($urandom_range(1) ? ita_pkg::ModeHex : ita_pkg::ModeDec,
                         pick_value());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, extremes, digit-count edges, most negative
    send_word(ita_pkg::ModeDec, 32'd0);
    send_word(ita_pkg::ModeHex, 32'd0);
    send_word(ita_pkg::ModeDec, 32'd1);
    send_word(ita_pkg::ModeDec, 32'hffff_ffff);
    send_word(ita_pkg::ModeDec, 32'h7fff_ffff);
    send_word(ita_pkg::ModeDec, 32'h8000_0000);
    send_word(ita_pkg::ModeDec, 32'h8000_0001);
    send_word(ita_pkg::ModeDec, 32'd9);
    send_word(ita_pkg::ModeDec, 32'd10);
    send_word(ita_pkg::ModeDec, 32'd99);
    send_word(ita_pkg::ModeDec, 32'd1000000000);
    send_word(ita_pkg::ModeDec, 32'd999999999);
    send_word(ita_pkg::ModeDec, 32'hffff_fff6);
    send_word(ita_pkg::ModeDec, 32'd123456789);
    send_word(ita_pkg::ModeHex, 32'hffff_ffff);
    send_word(ita_pkg::ModeHex, 32'h0000_000f);
    send_word(ita_pkg::ModeHex, 32'h0000_0010);
    send_word(ita_pkg::ModeHex, 32'hdead_beef);
    send_word(ita_pkg::ModeHex, 32'h8000_0000);
    send_word(ita_pkg::ModeHex, 32'h7fff_ffff);
    send_word(ita_pkg::ModeHex, 32'h0123_4567);

    send_idle_pct = 14;
    recv_idle_pct = 62;
    run_random(WordsPerPhase);

    send_idle_pct = 62;
    recv_idle_pct = 14;
    run_random(WordsPerPhase);

    // back-to-back words against a long output hold to fill the pipe
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs++;
    run_random(WordsPerPhase);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d words (%0d decimal, %0d hex) with zero, extremes and sign edges,",
             sb.dec_words + sb.hex_words, sb.dec_words, sb.hex_words);
    $display("idle mixes on both sides and a %0d-cycle output hold; %0d characters checked",
             HoldCycles, sb.chars_seen);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d characters still expected", sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ita_pkg.sv
rtl/ita_cell.sv
rtl/integer_to_ascii_formatter.sv
dv/tb_integer_to_ascii_formatter.sv
